// ===== hdl/mke_pkg.sv =====
// ----------------------------------------------------------------------------
// mke_pkg: Morse keying encoder definitions
// Sign table, segment and jump codes, and the microcode store of the
// sequencer that steps through one character.
// ----------------------------------------------------------------------------
`default_nettype none

package mke_pkg;

    localparam int CharW  = 8;
    localparam int UnitW  = 6;
    localparam int SymW   = 6;
    localparam int SymCntW = 3;
    localparam int CfgIdxW = 3;
    localparam int PcW    = 3;

    typedef logic [PcW-1:0]   pc_t;
    typedef logic [UnitW-1:0] units_t;

    // Register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] CFG_DASH      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SYM_GAP   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CHAR_GAP  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_WORD_GAP  = 3'd3;

    localparam units_t DASH_RST     = 6'd3;
    localparam units_t SYM_GAP_RST  = 6'd1;
    localparam units_t CHAR_GAP_RST = 6'd2;
    localparam units_t WORD_GAP_RST = 6'd10;
    localparam units_t DOT_UNITS    = 6'd1;

    // Microprogram addresses
    localparam pc_t PC_WAIT   = 3'd0;
    localparam pc_t PC_DECODE = 3'd1;
    localparam pc_t PC_CHECK  = 3'd2;
    localparam pc_t PC_CGAP   = 3'd3;
    localparam pc_t PC_MARK   = 3'd4;
    localparam pc_t PC_SGAP   = 3'd5;
    localparam pc_t PC_DONE   = 3'd6;
    localparam pc_t PC_SPACE  = 3'd7;

    typedef enum logic [2:0] {
        SEG_NONE,
        SEG_WORD,
        SEG_CHAR,
        SEG_MARK,
        SEG_SYM
    } seg_t;

    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_NEVER,
        JC_NO_INPUT,
        JC_SPACE,
        JC_UNKNOWN,
        JC_MORE
    } jc_t;

    typedef enum logic [1:0] {
        FL_NONE,
        FL_SPACE,
        FL_CHAR
    } flag_t;

    typedef struct packed {
        logic  take;
        logic  load;
        logic  shift;
        seg_t  seg;
        flag_t flag;
        jc_t   jc;
        pc_t   target;
    } ctrl_t;

    // Symbols are left aligned: the first one sits in the top bit, 1 is a dash
    typedef struct packed {
        logic                 known;
        logic [SymCntW-1:0]   cnt;
        logic [SymW-1:0]      bits;
    } sign_t;

    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t w;
        w = '{take: 1'b0, load: 1'b0, shift: 1'b0, seg: SEG_NONE, flag: FL_NONE,
              jc: JC_NEVER, target: PC_WAIT};
        unique case (pc)
            PC_WAIT:   begin w.take = 1'b1; w.jc = JC_NO_INPUT; end
            PC_DECODE: begin w.load = 1'b1; w.jc = JC_SPACE; w.target = PC_SPACE; end
            PC_CHECK:  begin w.jc = JC_UNKNOWN; end
            PC_CGAP:   begin w.seg = SEG_CHAR; end
            PC_MARK:   begin w.seg = SEG_MARK; end
            PC_SGAP:   begin
                w.seg = SEG_SYM; w.shift = 1'b1; w.jc = JC_MORE; w.target = PC_MARK;
            end
            PC_DONE:   begin w.flag = FL_CHAR; w.jc = JC_ALWAYS; end
            PC_SPACE:  begin w.seg = SEG_WORD; w.flag = FL_SPACE; w.jc = JC_ALWAYS; end
            default:   begin w.jc = JC_ALWAYS; end
        endcase
        return w;
    endfunction

    function automatic logic is_space(input logic [CharW-1:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic units_t at_least_one(input units_t v);
        return (v == '0) ? DOT_UNITS : v;
    endfunction

    function automatic sign_t lookup(input logic [CharW-1:0] c_in);
        logic [CharW-1:0] c;
        sign_t s;
        c = c_in;
        if (c >= "a" && c <= "z")
            c = c - 8'd32;
        s = '{known: 1'b1, cnt: 3'd0, bits: 6'b000000};
        unique case (c)
            "A": s = '{1'b1, 3'd2, 6'b010000};
            "B": s = '{1'b1, 3'd4, 6'b100000};
            "C": s = '{1'b1, 3'd4, 6'b101000};
            "D": s = '{1'b1, 3'd3, 6'b100000};
            "E": s = '{1'b1, 3'd1, 6'b000000};
            "F": s = '{1'b1, 3'd4, 6'b001000};
            "G": s = '{1'b1, 3'd3, 6'b110000};
            "H": s = '{1'b1, 3'd4, 6'b000000};
            "I": s = '{1'b1, 3'd2, 6'b000000};
            "J": s = '{1'b1, 3'd4, 6'b011100};
            "K": s = '{1'b1, 3'd3, 6'b101000};
            "L": s = '{1'b1, 3'd4, 6'b010000};
            "M": s = '{1'b1, 3'd2, 6'b110000};
            "N": s = '{1'b1, 3'd2, 6'b100000};
            "O": s = '{1'b1, 3'd3, 6'b111000};
            "P": s = '{1'b1, 3'd4, 6'b011000};
            "Q": s = '{1'b1, 3'd4, 6'b110100};
            "R": s = '{1'b1, 3'd3, 6'b010000};
            "S": s = '{1'b1, 3'd3, 6'b000000};
            "T": s = '{1'b1, 3'd1, 6'b100000};
            "U": s = '{1'b1, 3'd3, 6'b001000};
            "V": s = '{1'b1, 3'd4, 6'b000100};
            "W": s = '{1'b1, 3'd3, 6'b011000};
            "X": s = '{1'b1, 3'd4, 6'b100100};
            "Y": s = '{1'b1, 3'd4, 6'b101100};
            "Z": s = '{1'b1, 3'd4, 6'b110000};
            "0": s = '{1'b1, 3'd5, 6'b111110};
            "1": s = '{1'b1, 3'd5, 6'b011110};
            "2": s = '{1'b1, 3'd5, 6'b001110};
            "3": s = '{1'b1, 3'd5, 6'b000110};
            "4": s = '{1'b1, 3'd5, 6'b000010};
            "5": s = '{1'b1, 3'd5, 6'b000000};
            "6": s = '{1'b1, 3'd5, 6'b100000};
            "7": s = '{1'b1, 3'd5, 6'b110000};
            "8": s = '{1'b1, 3'd5, 6'b111000};
            "9": s = '{1'b1, 3'd5, 6'b111100};
            ".": s = '{1'b1, 3'd6, 6'b010101};
            ",": s = '{1'b1, 3'd6, 6'b110011};
            "?": s = '{1'b1, 3'd6, 6'b001100};
            "!": s = '{1'b1, 3'd6, 6'b101011};
            "/": s = '{1'b1, 3'd5, 6'b100100};
            "-": s = '{1'b1, 3'd6, 6'b100001};
            "=": s = '{1'b1, 3'd5, 6'b100010};
            "+": s = '{1'b1, 3'd5, 6'b010100};
            "@": s = '{1'b1, 3'd6, 6'b011010};
            "(": s = '{1'b1, 3'd5, 6'b101100};
            ")": s = '{1'b1, 3'd6, 6'b101101};
            ":": s = '{1'b1, 3'd6, 6'b111000};
            default: s = '{1'b0, 3'd0, 6'b000000};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/morse_keying_encoder.sv =====
// ----------------------------------------------------------------------------
// morse_keying_encoder
// Turns ASCII characters into runs of key-down / key-up segments in dot units.
// ----------------------------------------------------------------------------
// One character is taken at a time. A keyed character passes through a take
// step, two decode steps, one letter-gap step that is spent whether or not a
// gap is due, a mark step and a gap step for each symbol, and a closing step;
// whitespace and unknown characters pass only the take, decode and one final step.
// The order of steps is set by
// the microcode sequencer, which issues at most one segment per cycle into a
// single output register; a stalled output holds the sequencer on the emitting
// step. Lower case folds to upper case, unknown characters yield nothing, and
// a register holding zero keys as one unit.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_keying_encoder
    import mke_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [UnitW-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [CharW-1:0]   char_code,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    key_down,
    output logic [UnitW-1:0]        length_units,
    output logic                    last_of_run
);

    units_t dash_reg, sym_gap_reg, char_gap_reg, word_gap_reg;

    pc_t                pc_reg, pc_next;
    logic [CharW-1:0]   char_reg;
    logic [SymCntW-1:0] cnt_reg;
    logic [SymW-1:0]    bits_reg;
    logic               known_reg;
    logic               emitted_reg, space_reg, sep_reg;

    logic               out_valid_reg;
    logic               key_down_reg, last_reg;
    units_t             len_reg;

    ctrl_t  ctrl;
    sign_t  sign;
    logic   word_ok, char_ok, emit_req, out_free, advance, jump;
    logic   seg_down, seg_last;
    units_t seg_len;

    assign ctrl = ucode(pc_reg);
    assign sign = lookup(char_reg);

    assign word_ok  = !space_reg && emitted_reg;
    assign char_ok  = emitted_reg && !sep_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        emit_req = 1'b0;
        seg_down = 1'b0;
        seg_len  = DOT_UNITS;
        seg_last = 1'b0;
        unique case (ctrl.seg)
            SEG_NONE: emit_req = 1'b0;
            SEG_WORD:
            begin
                emit_req = word_ok;
                seg_len  = at_least_one(word_gap_reg);
                seg_last = 1'b1;
            end
            SEG_CHAR:
            begin
                emit_req = char_ok;
                seg_len  = at_least_one(char_gap_reg);
            end
            SEG_MARK:
            begin
                emit_req = 1'b1;
                seg_down = 1'b1;
                seg_len  = bits_reg[SymW-1] ? at_least_one(dash_reg) : DOT_UNITS;
            end
            SEG_SYM:
            begin
                emit_req = 1'b1;
                seg_len  = at_least_one(sym_gap_reg);
                seg_last = (cnt_reg == SymCntW'(1));
            end
            default: emit_req = 1'b0;
        endcase
    end

    // hold the step while its segment cannot be placed
    assign advance = !emit_req || out_free;

    always_comb
    begin
        unique case (ctrl.jc)
            JC_ALWAYS:   jump = 1'b1;
            JC_NEVER:    jump = 1'b0;
            JC_NO_INPUT: jump = !in_valid;
            JC_SPACE:    jump = is_space(char_reg);
            JC_UNKNOWN:  jump = !known_reg;
            JC_MORE:     jump = (cnt_reg > SymCntW'(1));
            default:     jump = 1'b1;
        endcase
        if (!advance)
            pc_next = pc_reg;
        else if (jump)
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + PcW'(1);
    end

    assign in_stall = !ctrl.take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_reg     <= DASH_RST;
            sym_gap_reg  <= SYM_GAP_RST;
            char_gap_reg <= CHAR_GAP_RST;
            word_gap_reg <= WORD_GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DASH:     dash_reg     <= cfg_data;
                CFG_SYM_GAP:  sym_gap_reg  <= cfg_data;
                CFG_CHAR_GAP: char_gap_reg <= cfg_data;
                CFG_WORD_GAP: word_gap_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_WAIT;
            emitted_reg   <= 1'b0;
            space_reg     <= 1'b0;
            sep_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (advance && emit_req)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                unique case (ctrl.flag)
                    FL_NONE:  ;
                    FL_SPACE:
                    begin
                        if (word_ok)
                            sep_reg <= 1'b1;
                        space_reg <= 1'b1;
                    end
                    FL_CHAR:
                    begin
                        emitted_reg <= 1'b1;
                        sep_reg     <= 1'b0;
                        space_reg   <= 1'b0;
                    end
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take && in_valid)
            char_reg <= char_code;
        if (ctrl.load)
        begin
            known_reg <= sign.known;
            cnt_reg   <= sign.cnt;
            bits_reg  <= sign.bits;
        end
        else if (ctrl.shift && advance)
        begin
            cnt_reg  <= cnt_reg - SymCntW'(1);
            bits_reg <= {bits_reg[SymW-2:0], 1'b0};
        end
        if (advance && emit_req)
        begin
            key_down_reg <= seg_down;
            len_reg      <= seg_len;
            last_reg     <= seg_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign key_down     = key_down_reg;
    assign length_units = len_reg;
    assign last_of_run  = last_reg;

`ifndef SYNTH
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length_units != '0)
        else $error("segment of zero length");

    a_mark_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_down |-> !last_of_run)
        else $error("run ends on key-down");

    a_mark_has_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == PC_MARK |-> cnt_reg != '0)
        else $error("mark step with no symbol left");

    a_take_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> pc_reg == PC_DECODE)
        else $error("accepted character not decoded next");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/mke_checker.sv =====
// ----------------------------------------------------------------------------
// mke_checker: segment predictor and scoreboard for morse_keying_encoder
// Watches the configuration port and both channels. Every accepted character
// is turned into its expected key segments, and every accepted output
// transaction is compared field by field with the oldest expected segment.
// ----------------------------------------------------------------------------
`default_nettype none

module mke_checker
    import mke_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [UnitW-1:0]   cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [CharW-1:0]   char_code,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic               key_down,
    input  wire logic [UnitW-1:0]   length_units,
    input  wire logic               last_of_run,
    output int                      mismatches,
    output int                      outstanding,
    output int                      chars_keyed,
    output int                      word_gaps,
    output int                      segments_checked
);

    localparam logic [CharW-1:0] CH_TAB   = 8'd9;
    localparam logic [CharW-1:0] CH_CR    = 8'd13;
    localparam logic [CharW-1:0] CH_SPACE = 8'd32;

    typedef struct packed {
        logic   key_down;
        units_t length_units;
        logic   last_of_run;
    } segment_t;

    segment_t expected_segments[$];

    units_t dash_len;
    units_t sym_gap_len;
    units_t char_gap_len;
    units_t word_gap_len;
    logic   keyed_any;
    logic   after_space;
    logic   after_word_gap;
    int     fail_total;
    int     keyed_total;
    int     gap_total;
    int     seen_total;

    // Dots and dashes of a character, empty when the character has no sign
    function automatic string sign_of(input logic [CharW-1:0] c);
        logic [CharW-1:0] u;
        u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        case (u)
            "A": return ".-";
            "B": return "-...";
            "C": return "-.-.";
            "D": return "-..";
            "E": return ".";
            "F": return "..-.";
            "G": return "--.";
            "H": return "....";
            "I": return "..";
            "J": return ".---";
            "K": return "-.-";
            "L": return ".-..";
            "M": return "--";
            "N": return "-.";
            "O": return "---";
            "P": return ".--.";
            "Q": return "--.-";
            "R": return ".-.";
            "S": return "...";
            "T": return "-";
            "U": return "..-";
            "V": return "...-";
            "W": return ".--";
            "X": return "-..-";
            "Y": return "-.--";
            "Z": return "--..";
            "0": return "-----";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            ".": return ".-.-.-";
            ",": return "--..--";
            "?": return "..--..";
            "!": return "-.-.--";
            "/": return "-..-.";
            "-": return "-....-";
            "=": return "-...-";
            "+": return ".-.-.";
            "@": return ".--.-.";
            "(": return "-.--.";
            ")": return "-.--.-";
            ":": return "---...";
            default: return "";
        endcase
    endfunction

    // A register left at zero keys as one unit
    function automatic units_t floor_one(input units_t v);
        return (v == '0) ? units_t'(1) : v;
    endfunction

    task automatic key_character(input logic [CharW-1:0] c);
        string    pattern;
        int       first;
        segment_t tail;
        first = expected_segments.size();
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
        begin
            if (!after_space && keyed_any)
            begin
                expected_segments.push_back('{1'b0, floor_one(word_gap_len), 1'b0});
                after_word_gap = 1'b1;
                gap_total++;
            end
            after_space = 1'b1;
        end
        else
        begin
            pattern = sign_of(c);
            if (pattern.len() == 0)
                return;
            if (keyed_any && !after_word_gap)
                expected_segments.push_back('{1'b0, floor_one(char_gap_len), 1'b0});
            for (int i = 0; i < pattern.len(); i++)
            begin
                if (pattern[i] == "-")
                    expected_segments.push_back('{1'b1, floor_one(dash_len), 1'b0});
                else
                    expected_segments.push_back('{1'b1, units_t'(1), 1'b0});
                expected_segments.push_back('{1'b0, floor_one(sym_gap_len), 1'b0});
            end
            keyed_any      = 1'b1;
            after_word_gap = 1'b0;
            after_space    = 1'b0;
            keyed_total++;
        end
        // mark the closing segment of this run
        if (expected_segments.size() > first)
        begin
            tail = expected_segments.pop_back();
            tail.last_of_run = 1'b1;
            expected_segments.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        segment_t want;
        if (!rst_n)
        begin
            expected_segments.delete();
            dash_len       = DASH_RST;
            sym_gap_len    = SYM_GAP_RST;
            char_gap_len   = CHAR_GAP_RST;
            word_gap_len   = WORD_GAP_RST;
            keyed_any      = 1'b0;
            after_space    = 1'b0;
            after_word_gap = 1'b0;
            fail_total     = 0;
            keyed_total    = 0;
            gap_total      = 0;
            seen_total     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DASH:     dash_len     = cfg_data;
                    CFG_SYM_GAP:  sym_gap_len  = cfg_data;
                    CFG_CHAR_GAP: char_gap_len = cfg_data;
                    CFG_WORD_GAP: word_gap_len = cfg_data;
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
                key_character(char_code);
            if (out_valid && !out_stall)
            begin
                if (expected_segments.size() == 0)
                begin
                    if (fail_total < 10)
                        $display("unexpected segment: down=%0b len=%0d last=%0b",
                                 key_down, length_units, last_of_run);
                    fail_total++;
                end
                else
                begin
                    want = expected_segments.pop_front();
                    if (key_down !== want.key_down || length_units !== want.length_units
                        || last_of_run !== want.last_of_run)
                    begin
                        if (fail_total < 10)
                            $display({"segment %0d mismatch: expected down=%0b len=%0d ",
                                      "last=%0b, got down=%0b len=%0d last=%0b"},
                                     seen_total, want.key_down, want.length_units,
                                     want.last_of_run, key_down, length_units, last_of_run);
                        fail_total++;
                    end
                end
                seen_total++;
            end
        end
        mismatches       <= fail_total;
        outstanding      <= expected_segments.size();
        chars_keyed      <= keyed_total;
        word_gaps        <= gap_total;
        segments_checked <= seen_total;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for morse_keying_encoder
// Drives characters and timing register settings, paces both channels at
// random with a long output hold-off, and leaves prediction and checking to
// mke_checker. Gives the verdict once every expected segment has arrived.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import mke_pkg::*;

    localparam int PHASES          = 8;
    localparam int CHARS_PER_PHASE = 23;
    localparam int HOLD_PHASE      = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic [CharW-1:0] CH_TAB   = 8'd9;
    localparam logic [CharW-1:0] CH_LF    = 8'd10;
    localparam logic [CharW-1:0] CH_VT    = 8'd11;
    localparam logic [CharW-1:0] CH_FF    = 8'd12;
    localparam logic [CharW-1:0] CH_CR    = 8'd13;
    localparam logic [CharW-1:0] CH_SPACE = 8'd32;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [CfgIdxW-1:0] cfg_index    = '0;
    logic [UnitW-1:0]   cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [CharW-1:0]   char_code    = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic               key_down;
    logic [UnitW-1:0]   length_units;
    logic               last_of_run;

    int mismatches;
    int outstanding;
    int chars_keyed;
    int word_gaps;
    int segments_checked;

    int send_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    string known_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?!/-=+@():";

    // leading and repeated whitespace, case folding, unknown codes, longest signs
    logic [CharW-1:0] opening_text [24] = '{
        CH_SPACE, CH_TAB, "E", "t", CH_SPACE, CH_LF, "0", "a",
        8'h00, 8'hFF, "Q", CH_VT, "z", ",", CH_SPACE, "!",
        CH_FF, CH_CR, ")", ":", 8'h80, "5", 8'h7F, "@"
    };

    always #6 clk = ~clk;

    morse_keying_encoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_down     (key_down),
        .length_units (length_units),
        .last_of_run  (last_of_run)
    );

    mke_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_code        (char_code),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .key_down         (key_down),
        .length_units     (length_units),
        .last_of_run      (last_of_run),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .chars_keyed      (chars_keyed),
        .word_gaps        (word_gaps),
        .segments_checked (segments_checked)
    );

    // Output side: random stall, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("** morse_keying_encoder: FAILED **");
        $finish;
    end

    task automatic send_char(input logic [CharW-1:0] c);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until the block has nothing left in flight
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_timing(input int phase);
        units_t timing [4];
        case (phase)
            1: timing = '{6'd63, 6'd63, 6'd63, 6'd63};
            2: timing = '{6'd0, 6'd0, 6'd0, 6'd0};
            3: timing = '{6'd1, 6'd1, 6'd1, 6'd1};
            5: timing = '{6'd63, 6'd1, 6'd0, 6'd63};
            7: timing = '{DASH_RST, SYM_GAP_RST, CHAR_GAP_RST, WORD_GAP_RST};
            default:
            begin
                foreach (timing[i])
                    timing[i] = units_t'($urandom_range(63));
            end
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DASH;
        cfg_data  <= timing[0];
        @(posedge clk);
        cfg_index <= CFG_SYM_GAP;
        cfg_data  <= timing[1];
        @(posedge clk);
        cfg_index <= CFG_CHAR_GAP;
        cfg_data  <= timing[2];
        @(posedge clk);
        cfg_index <= CFG_WORD_GAP;
        cfg_data  <= timing[3];
        @(posedge clk);
        // unmapped index: must leave every register alone
        cfg_index <= CFG_WORD_GAP + CfgIdxW'($urandom_range(4, 1));
        cfg_data  <= units_t'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [CharW-1:0] c;
        int               keyed;
        int               roll;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0: begin send_pct = 0;  stall_pct <= 0;  end
                1: begin send_pct = 73; stall_pct <= 0;  end
                2: begin send_pct = 0;  stall_pct <= 73; end
                default: begin send_pct = 32; stall_pct <= 32; end
            endcase
            if (phase > 0)
                program_timing(phase);
            if (phase == 0)
                foreach (opening_text[i])
                    send_char(opening_text[i]);
            if (phase == HOLD_PHASE)
                hold_requests <= hold_requests + 1;
            keyed = 0;
            while (keyed < CHARS_PER_PHASE)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                begin
                    c = known_chars[$urandom_range(known_chars.len() - 1)];
                    if (c >= "A" && c <= "Z" && $urandom_range(1) == 1)
                        c = c + 8'd32;
                    keyed++;
                end
                else if (roll < 85)
                    c = ($urandom_range(1) == 1) ? CH_SPACE
                        : CH_TAB + CharW'($urandom_range(CH_CR - CH_TAB));
                else
                    c = CharW'($urandom_range(255));
                send_char(c);
            end
            settle();
        end
        $display("covered %0d keyed characters, %0d word gaps, %0d segments checked",
                 chars_keyed, word_gaps, segments_checked);
        $display("over %0d register settings (reset, zero, one, full scale, random)",
                 PHASES);
        if (mismatches == 0 && outstanding == 0)
            $display("** morse_keying_encoder: PASSED **");
        else
            $display("** morse_keying_encoder: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
